// ----- hw/rtl/caseless_wildcard_name_matcher_core_defines.svh -----
// ---------------------------------------------------------------------------
// caseless wildcard name matcher: assertion macros
// shared property forms for the matcher's concurrent checks
// ---------------------------------------------------------------------------
`ifndef CASELESS_WILDCARD_NAME_MATCHER_CORE_DEFINES_SVH
`define CASELESS_WILDCARD_NAME_MATCHER_CORE_DEFINES_SVH

// same-cycle implication, checks off while reset is held
`define CWM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checks off while reset is held
`define CWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/cwm_pkg.sv -----
// ---------------------------------------------------------------------------
// cwm_pkg
// constants, types and the character fold shared by the name matcher
// ---------------------------------------------------------------------------
package cwm_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int CHAR_W      = 16;
    localparam int PAT_CHARS   = 16;          // characters held by the pattern registers
    localparam int PAT_REGS    = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int MODE_W      = 3;
    localparam int LEN_REG_W   = 5;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int CNT_W       = $clog2(MAX_PATTERN + 2);
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // match kinds
    localparam logic [MODE_W-1:0] MODE_EXACT     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PREFIX    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SUFFIX    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SUBSTRING = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ALL       = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_A = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_B = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_C = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_D = 3'd5;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [MAX_PATTERN-1:0][CHAR_W-1:0] t_char_vec;

    // settings seen by the tracker
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [LEN_W-1:0]  len;    // length in use, limited to MAX_PATTERN
        t_char_vec         fwd;    // folded pattern, character 0 at entry 0
        t_char_vec         rev;    // folded pattern reversed, last character at entry 0
    } t_cfg;

    // ascii upper case to lower case, all else unchanged
    function automatic t_char fold_char(input t_char c);
        if ((c >= 16'h0041) && (c <= 16'h005A)) begin
            return c + 16'h0020;
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/cwm_cfg.sv -----
// ---------------------------------------------------------------------------
// cwm_cfg
// configuration registers and the folded, aligned views of the pattern
// ---------------------------------------------------------------------------
module cwm_cfg
    import cwm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [MODE_W-1:0]                  r_mode;
    logic [LEN_REG_W-1:0]               r_len;
    logic [PAT_REGS-1:0][CFG_DATA_W-1:0] r_pat;
    logic [PAT_CHARS*CHAR_W-1:0]        pat_flat;
    logic [LEN_W-1:0]                   len_used;
    t_char_vec                          pat_fwd;
    t_char_vec                          pat_rev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0;
            r_len  <= '0;
            r_pat  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODE:  r_mode   <= i_cfg_data[MODE_W-1:0];
                CFG_LEN:   r_len    <= i_cfg_data[LEN_REG_W-1:0];
                CFG_PAT_A: r_pat[0] <= i_cfg_data;
                CFG_PAT_B: r_pat[1] <= i_cfg_data;
                CFG_PAT_C: r_pat[2] <= i_cfg_data;
                CFG_PAT_D: r_pat[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign pat_flat = r_pat;

    always_comb begin
        if (int'(r_len) > MAX_PATTERN) begin
            len_used = LEN_W'(MAX_PATTERN);
        end else begin
            len_used = LEN_W'(r_len);
        end
    end

    // characters past the register file read as zero
    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (i < PAT_CHARS) begin
                pat_fwd[i] = fold_char(pat_flat[i*CHAR_W +: CHAR_W]);
            end else begin
                pat_fwd[i] = '0;
            end
        end
    end

    // entry k pairs with window entry k (newest first)
    always_comb begin
        logic [LEN_W-1:0] src;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            src = LEN_W'(len_used - LEN_W'(1) - LEN_W'(k));
            if (LEN_W'(k) < len_used) begin
                pat_rev[k] = pat_fwd[src[IDX_W-1:0]];
            end else begin
                pat_rev[k] = '0;
            end
        end
    end

    assign o_cfg.mode = r_mode;
    assign o_cfg.len  = len_used;
    assign o_cfg.fwd  = pat_fwd;
    assign o_cfg.rev  = pat_rev;

endmodule

// ----- hw/rtl/cwm_track.sv -----
// ---------------------------------------------------------------------------
// cwm_track
// per-name state: recent window, prefix and substring flags, count,
// and the match decision on the word that ends a name
// ---------------------------------------------------------------------------
module cwm_track
    import cwm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_go,
    input  t_char i_char,
    input  logic  i_has,
    input  logic  i_last,
    input  t_cfg  i_cfg,
    output logic  o_matched
);

    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_PATTERN + 1);

    t_char_vec        r_window, n_window;
    logic             r_prefix_ok, n_prefix_ok;
    logic             r_sub_found, n_sub_found;
    logic [CNT_W-1:0] r_count, n_count;

    t_char            fc;
    logic [CNT_W-1:0] len_c;
    logic             tail_hit;

    assign fc    = fold_char(i_char);
    assign len_c = CNT_W'(i_cfg.len);

    always_comb begin
        n_window = r_window;
        n_count  = r_count;
        if (i_has) begin
            n_window = {r_window[MAX_PATTERN-2:0], fc};
            if (r_count != CNT_SAT) begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    // prefix check uses the count before this character
    always_comb begin
        n_prefix_ok = r_prefix_ok;
        if (i_has && (r_count < len_c)
                && (fc != i_cfg.fwd[r_count[IDX_W-1:0]])) begin
            n_prefix_ok = 1'b0;
        end
    end

    // newest len characters against the pattern, all lanes in parallel
    always_comb begin
        tail_hit = (n_count >= len_c);
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if ((LEN_W'(k) < i_cfg.len) && (n_window[k] != i_cfg.rev[k])) begin
                tail_hit = 1'b0;
            end
        end
    end

    assign n_sub_found = r_sub_found | (i_has & tail_hit);

    always_comb begin
        unique case (i_cfg.mode)
            MODE_EXACT:     o_matched = n_prefix_ok && (n_count == len_c);
            MODE_PREFIX:    o_matched = n_prefix_ok && (n_count >= len_c);
            MODE_SUFFIX:    o_matched = tail_hit;
            MODE_SUBSTRING: o_matched = (i_cfg.len == '0) || n_sub_found;
            MODE_ALL:       o_matched = 1'b1;
            default:        o_matched = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= '0;
            r_prefix_ok <= 1'b1;
            r_sub_found <= 1'b0;
            r_count     <= '0;
        end else if (i_go) begin
            if (i_last) begin
                r_window    <= '0;
                r_prefix_ok <= 1'b1;
                r_sub_found <= 1'b0;
                r_count     <= '0;
            end else begin
                r_window    <= n_window;
                r_prefix_ok <= n_prefix_ok;
                r_sub_found <= n_sub_found;
                r_count     <= n_count;
            end
        end
    end

endmodule

// ----- hw/rtl/caseless_wildcard_name_matcher_core.sv -----
// ---------------------------------------------------------------------------
// caseless_wildcard_name_matcher_core
// streams a name one character per word and reports a caseless match
// ---------------------------------------------------------------------------
// One word is taken every clock unless an end-of-name word is waiting. A
// word sits in the input register while the window compare (all sixteen
// lanes side by side) updates the name state; the word that ends a name
// then writes its result to the output register, which holds it until it
// is taken. Only an end-of-name word
// can wait, and only while the output register still holds an untaken
// result; intake stops while it waits. Words inside a name never wait in
// the input register. No clearing pass.
module caseless_wildcard_name_matcher_core
    import cwm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [CHAR_W-1:0]     i_symbol_char,
    input  logic                  i_has_char,
    input  logic                  i_end_of_name,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_matched,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "caseless_wildcard_name_matcher_core_defines.svh"

    logic  r_in_valid;
    t_char r_char;
    logic  r_has;
    logic  r_last;
    logic  r_out_valid;
    logic  r_matched;

    logic  out_free;
    logic  s1_go;
    logic  matched;
    t_cfg  cfg;

    cwm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    cwm_track u_track (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (s1_go),
        .i_char    (r_char),
        .i_has     (r_has),
        .i_last    (r_last),
        .i_cfg     (cfg),
        .o_matched (matched)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_go      = r_in_valid && (!r_last || out_free);
    assign o_in_ready = !r_in_valid || s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_char <= i_symbol_char;
            r_has  <= i_has_char;
            r_last <= i_end_of_name;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_last) begin
            r_matched <= matched;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_matched   = r_matched;

    // words inside a name never stall
    `CWM_ASSERT_NOW(a_mid_name_flows, i_clk, i_rst_n, r_in_valid && !r_last, s1_go,
        "mid-name word held in input register")
    // an end word always lands in the output register
    `CWM_ASSERT_NEXT(a_end_gives_result, i_clk, i_rst_n, s1_go && r_last, r_out_valid,
        "end of name produced no result")
    // a pending end word blocks intake while the result is not taken
    `CWM_ASSERT_NOW(a_end_blocks, i_clk, i_rst_n,
        r_in_valid && r_last && r_out_valid && !i_out_ready, !o_in_ready && !s1_go,
        "end word advanced over an untaken result")

endmodule

// ----- verif/tb_caseless_wildcard_name_matcher_core.sv -----
// ---------------------------------------------------------------------------
// tb_caseless_wildcard_name_matcher_core
// Streams names into the matcher one word at a time. The run switches through
// many pattern and mode settings. A scoreboard keeps its own copy of the
// window, the flags and the count, works out the match bit for every name
// and checks it against the result port. Both ports idle at random.
// ---------------------------------------------------------------------------
module tb_caseless_wildcard_name_matcher_core;
    timeunit 1ns;
    timeprecision 1ps;
    import cwm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;
    localparam logic [MODE_W-1:0]    MODE_SPARE    = 3'd5;

    localparam int PHASES         = 14;
    localparam int PHASE_ITEMS    = 80;
    localparam int PRESSURE_PHASE = 9;
    localparam int LONG_HOLD      = 80;
    localparam int SETTLE_CYCLES  = 4;
    localparam int MAX_PRINTED    = 40;

    // keeps its own copy of the name state and works out each match bit
    class name_match_tracker;
        logic [MODE_W-1:0]     mode_q;
        logic [LEN_REG_W-1:0]  len_q;
        logic [CFG_DATA_W-1:0] chars_q [PAT_REGS];
        t_char                 window_q [MAX_PATTERN];
        bit                    prefix_ok_q;
        bit                    inside_q;
        int unsigned           count_q;
        bit                    expected_matched [$];
        int                    fault_count;
        int                    names_done;
        int                    hits;

        function new();
            mode_q = '0;
            len_q  = '0;
            foreach (chars_q[i]) chars_q[i] = '0;
            fault_count = 0;
            names_done  = 0;
            hits        = 0;
            restart_name();
        endfunction

        function void restart_name();
            foreach (window_q[i]) window_q[i] = '0;
            prefix_ok_q = 1'b1;
            inside_q    = 1'b0;
            count_q     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MODE: begin
                    mode_q = data[MODE_W-1:0];
                end
                CFG_LEN: begin
                    len_q = data[LEN_REG_W-1:0];
                end
                CFG_PAT_A, CFG_PAT_B, CFG_PAT_C, CFG_PAT_D: begin
                    chars_q[idx - CFG_PAT_A] = data;
                end
                default: begin
                end
            endcase
        endfunction

        function t_char lower_ascii(t_char c);
            if (c >= 16'h0041 && c <= 16'h005A) begin
                return c + 16'h0020;
            end
            return c;
        endfunction

        function t_char pat_char(int unsigned i);
            if (i >= PAT_CHARS) begin
                return '0;
            end
            return chars_q[i / 4][(i % 4) * CHAR_W +: CHAR_W];
        endfunction

        function int unsigned len_in_use();
            return (len_q > MAX_PATTERN) ? MAX_PATTERN : len_q;
        endfunction

        // newest n window entries against the pattern, last character first
        function bit tail_hit(int unsigned n);
            if (count_q < n) begin
                return 1'b0;
            end
            for (int k = 0; k < n; k++) begin
                if (lower_ascii(window_q[k]) != lower_ascii(pat_char(n - 1 - k))) begin
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function void take_word(t_char c, bit has, bit last);
            int unsigned n;
            bit          m;
            n = len_in_use();
            if (has) begin
                if (count_q < n && lower_ascii(c) != lower_ascii(pat_char(count_q))) begin
                    prefix_ok_q = 1'b0;
                end
                for (int k = MAX_PATTERN - 1; k > 0; k--) begin
                    window_q[k] = window_q[k - 1];
                end
                window_q[0] = c;
                if (count_q < MAX_PATTERN + 1) begin
                    count_q++;
                end
                if (tail_hit(n)) begin
                    inside_q = 1'b1;
                end
            end
            if (!last) begin
                return;
            end
            case (mode_q)
                MODE_EXACT:     m = prefix_ok_q && (count_q == n);
                MODE_PREFIX:    m = prefix_ok_q && (count_q >= n);
                MODE_SUFFIX:    m = tail_hit(n);
                MODE_SUBSTRING: m = (n == 0) || inside_q;
                MODE_ALL:       m = 1'b1;
                default:        m = 1'b0;
            endcase
            expected_matched.push_back(m);
            restart_name();
        endfunction

        function int pending();
            return expected_matched.size();
        endfunction

        task report_fault(string what);
            fault_count++;
            if (fault_count <= MAX_PRINTED) begin
                $display("%0t ns: mismatch: %s", $time, what);
            end
        endtask

        task check_matched(logic got);
            bit want;
            if (expected_matched.size() == 0) begin
                report_fault($sformatf("result %b with no name pending", got));
                return;
            end
            want = expected_matched.pop_front();
            names_done++;
            if (want) begin
                hits++;
            end
            if (got !== want) begin
                report_fault($sformatf("name %0d: matched %b, expected %b",
                                       names_done, got, want));
            end
        endtask
    endclass

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic [CHAR_W-1:0]     symbol_char = '0;
    logic                  has_char    = 1'b0;
    logic                  end_of_name = 1'b0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic                  matched;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    name_match_tracker tracker = new();

    t_char       pat_text [PAT_CHARS];
    int unsigned pat_used      = 0;
    int          burst_left    = 0;
    bit          steady        = 1'b1;
    bit          hold_out      = 1'b0;
    bit          hold_active   = 1'b0;
    int          items_sent    = 0;
    int          settings_done = 0;

    caseless_wildcard_name_matcher_core dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_symbol_char (symbol_char),
        .i_has_char    (has_char),
        .i_end_of_name (end_of_name),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_matched     (matched),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial begin
        #1_000_000;
        $display("[caseless_wildcard_name_matcher_core] ERROR");
        $finish;
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            tracker.check_matched(matched);
        end
    end

    // result side: stall patterns of its own, plus one long hold on request
    initial begin : receiver
        int seg;
        int stall_pct;
        forever begin
            if (hold_out) begin
                out_ready   <= 1'b0;
                hold_active = 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_out    = 1'b0;
                hold_active = 1'b0;
            end else begin
                seg = $urandom_range(40, 5);
                case ($urandom_range(3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 30;
                    2:       stall_pct = 70;
                    default: stall_pct = 95;
                endcase
                repeat (seg) begin
                    out_ready <= ($urandom_range(99) >= stall_pct);
                    @(posedge clk);
                end
            end
        end
    end

    function automatic t_char random_char();
        t_char edges [6] = '{16'h0040, 16'h005B, 16'h0060, 16'h007B, 16'h0000, 16'hFFFF};
        case ($urandom_range(9))
            0, 1:    return t_char'(16'h0061 + $urandom_range(2));
            2, 3:    return t_char'(16'h0061 + $urandom_range(25));
            4, 5:    return t_char'(16'h0041 + $urandom_range(25));
            6:       return edges[$urandom_range(5)];
            default: return t_char'($urandom);
        endcase
    endfunction

    function automatic t_char flip_case(t_char c);
        if ($urandom_range(1) == 0) begin
            return c;
        end
        if (c >= 16'h0061 && c <= 16'h007A) begin
            return c - 16'h0020;
        end
        if (c >= 16'h0041 && c <= 16'h005A) begin
            return c + 16'h0020;
        end
        return c;
    endfunction

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        tracker.write_reg(idx, data);
    endtask

    // noisy puts junk in the unused upper bits and hits a spare index
    task automatic load_setting(logic [MODE_W-1:0] mode, logic [LEN_REG_W-1:0] len,
                                bit noisy);
        logic [CFG_DATA_W-1:0] word;
        logic [CFG_DATA_W-1:0] packed_chars [PAT_REGS];
        for (int i = 0; i < PAT_CHARS; i++) begin
            packed_chars[i / 4][(i % 4) * CHAR_W +: CHAR_W] = pat_text[i];
        end
        word = noisy ? {$urandom, $urandom} : '0;
        word[MODE_W-1:0] = mode;
        cfg_write(CFG_MODE, word);
        word = noisy ? {$urandom, $urandom} : '0;
        word[LEN_REG_W-1:0] = len;
        cfg_write(CFG_LEN, word);
        for (int r = 0; r < PAT_REGS; r++) begin
            cfg_write(CFG_IDX_W'(CFG_PAT_A + r), packed_chars[r]);
        end
        if (noisy) begin
            cfg_write($urandom_range(1) ? CFG_UNUSED_LO : CFG_UNUSED_HI, {$urandom, $urandom});
        end
        cfg_we   <= 1'b0;
        pat_used = (len > MAX_PATTERN) ? MAX_PATTERN : len;
        settings_done++;
    endtask

    // sender stops and waits out every pending name before a setting change
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_word(t_char c, bit has, bit last);
        int gap;
        if (!steady && burst_left == 0) begin
            burst_left = $urandom_range(30, 1);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        in_valid    <= 1'b1;
        symbol_char <= c;
        has_char    <= has;
        end_of_name <= last;
        do @(posedge clk); while (in_ready !== 1'b1);
        tracker.take_word(c, has, last);
        items_sent++;
    endtask

    task automatic send_name(bit short_only);
        t_char text [$];
        int    kind;
        int    head;
        int    tail;
        int    body;
        bit    trailing;
        kind = short_only ? 7 : $urandom_range(7);
        head = (kind == 2) ? $urandom_range(5, 1) : (kind == 3) ? $urandom_range(6) : 0;
        tail = (kind == 1) ? $urandom_range(5, 1) : (kind == 3) ? $urandom_range(6) : 0;
        body = (kind >= 6) ? 0 : (kind == 5) ? $urandom_range(pat_used) : pat_used;
        repeat (head) text.push_back(random_char());
        for (int i = 0; i < body; i++) begin
            text.push_back(flip_case(pat_text[i]));
        end
        repeat (tail) text.push_back(random_char());
        if (kind == 4 && text.size() != 0) begin
            text[$urandom_range(text.size() - 1)] = random_char();
        end
        if (kind == 6) begin
            repeat ($urandom_range(20)) text.push_back(random_char());
        end else if (kind == 7) begin
            repeat ($urandom_range(3)) text.push_back(random_char());
        end
        trailing = ($urandom_range(3) == 0);
        foreach (text[i]) begin
            // a stray word with no character now and then
            if ($urandom_range(19) == 0) begin
                send_word(t_char'($urandom), 1'b0, 1'b0);
            end
            send_word(text[i], 1'b1, (i == text.size() - 1) && !trailing);
        end
        if (text.size() == 0 || trailing) begin
            send_word(t_char'($urandom), 1'b0, 1'b1);
        end
    endtask

    initial begin : stimulus
        int                   start;
        logic [MODE_W-1:0]    mode;
        logic [LEN_REG_W-1:0] len;
        foreach (pat_text[i]) pat_text[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty name against the reset setting
        send_word(16'hFFFF, 1'b0, 1'b1);

        // unused mode code
        settle();
        load_setting(MODE_SPARE, 5'd0, 1'b0);
        send_word(16'h0078, 1'b1, 1'b1);

        // prefix and exact with a folded letter and a full-scale character
        settle();
        pat_text[0] = 16'h0041;
        pat_text[1] = 16'hFFFF;
        load_setting(MODE_PREFIX, 5'd2, 1'b0);
        send_word(16'h0061, 1'b1, 1'b0);
        send_word(16'hFFFF, 1'b1, 1'b0);
        send_word(16'h005A, 1'b1, 1'b1);
        settle();
        load_setting(MODE_EXACT, 5'd2, 1'b0);
        send_word(16'h0061, 1'b1, 1'b0);
        send_word(16'hFFFF, 1'b1, 1'b1);

        // empty pattern in substring mode, empty name in match-all mode
        settle();
        load_setting(MODE_SUBSTRING, 5'd0, 1'b0);
        send_word(16'h0000, 1'b1, 1'b1);
        settle();
        load_setting(MODE_ALL, 5'd0, 1'b0);
        send_word(16'h0000, 1'b0, 1'b1);

        // oversized length limited to sixteen, name closed by a bare end word
        settle();
        pat_text = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0040, 16'h0041,
                     16'h005A, 16'h005B, 16'h0060, 16'h0061, 16'h007A, 16'h007B,
                     16'h0141, 16'h5A5A, 16'hA5A5, 16'h00DF};
        load_setting(MODE_SUFFIX, 5'd31, 1'b0);
        for (int i = 0; i < PAT_CHARS; i++) begin
            send_word(flip_case(pat_text[i]), 1'b1, 1'b0);
        end
        send_word(16'h1234, 1'b0, 1'b1);

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            mode = (ph < 8) ? MODE_W'(ph) :
                   ($urandom_range(5) == 0) ? MODE_W'($urandom_range(7, 5)) :
                                              MODE_W'($urandom_range(4));
            case (ph)
                0: len = 5'd0;
                1: len = 5'd31;
                2: len = 5'd16;
                default: begin
                    case ($urandom_range(5))
                        0:       len = LEN_REG_W'($urandom_range(3, 1));
                        1, 2:    len = LEN_REG_W'($urandom_range(8, 1));
                        3:       len = LEN_REG_W'($urandom_range(16, 9));
                        4:       len = 5'd16;
                        default: len = LEN_REG_W'($urandom_range(31, 17));
                    endcase
                end
            endcase
            foreach (pat_text[i]) begin
                pat_text[i] = (ph == 3) ? 16'h0000 : (ph == 5) ? 16'hFFFF : random_char();
            end
            load_setting(mode, len, $urandom_range(1));
            steady = ($urandom_range(3) == 0);
            start  = items_sent;
            if (ph == PRESSURE_PHASE) begin
                // output held off long enough that end words back up
                steady   = 1'b1;
                hold_out = 1'b1;
                while (!hold_active) @(posedge clk);
            end
            while (items_sent - start < PHASE_ITEMS) begin
                send_name(ph == PRESSURE_PHASE);
            end
        end

        settle();
        repeat (8) @(posedge clk);
        $display("covered %0d words in %0d names over %0d settings",
                 items_sent, tracker.names_done, settings_done);
        $display("%0d names matched, %0d did not", tracker.hits,
                 tracker.names_done - tracker.hits);
        if (tracker.fault_count == 0) begin
            $display("[caseless_wildcard_name_matcher_core] OK");
        end else begin
            $display("[caseless_wildcard_name_matcher_core] ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/cwm_pkg.sv
hw/rtl/cwm_cfg.sv
hw/rtl/cwm_track.sv
hw/rtl/caseless_wildcard_name_matcher_core.sv
verif/tb_caseless_wildcard_name_matcher_core.sv
